[design/assert_macros.svh]
// Assertion shorthands for the RTL, used by pixel_colorize_hsl.
// Expects clk and rst_n (synchronous, active low) in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition must hold on every clock edge out of reset.
`define AST_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

`endif

[design/pch_pkg.sv]
// Package for pixel_colorize_hsl: widths, register indexes, stage types,
// fixed-point helpers (divide by ONE, hue segment lookup). No dependencies.
package pch_pkg;

  localparam int CHAN_W  = 16;
  localparam int DATA_W  = 64;
  localparam int WGT_W   = 17;
  localparam int SHIFT_W = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG    = 8;
  localparam int NCH     = 3;

  localparam logic [CHAN_W-1:0] ONE      = 16'hFFFF;
  localparam logic [CHAN_W-1:0] HALF_ONE = 16'h7FFF;

  // hue positions, units of ONE, signed 21 bits
  localparam logic signed [20:0] ONE_S    = 21'sd65535;
  localparam logic signed [20:0] TWO_ONE  = 21'sd131070;
  localparam logic signed [20:0] THREE_ONE = 21'sd196605;
  localparam logic signed [20:0] FOUR_ONE = 21'sd262140;
  localparam logic signed [20:0] SIX_ONE  = 21'sd393210;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE    = 3'd0,
    REG_SAT    = 3'd1,
    REG_SHIFT  = 3'd2,
    REG_WRED   = 3'd3,
    REG_WGREEN = 3'd4,
    REG_WBLUE  = 3'd5
  } cfg_reg_t;

  // piece of the hue ramp a channel falls on
  typedef enum logic [1:0] {
    SEG_RAMP = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_LOW  = 2'd2
  } seg_t;

  typedef struct packed {
    seg_t              seg;
    logic [CHAN_W-1:0] fac;
  } ramp_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } side_t;

  // floor(x / 65535), exact for quotients up to 65535
  function automatic logic [CHAN_W-1:0] div_one(input logic [33:0] x);
    logic [33:0] s;
    s = x + {16'b0, x[33:16]} + 34'd1;
    return s[31:16];
  endfunction

  // segment and ramp factor for position 6*hue + off, wrapped to one turn
  function automatic ramp_t hue_seg(input logic [CHAN_W-1:0] hue,
                                    input logic signed [20:0] off);
    logic signed [20:0] t;
    logic signed [20:0] back;
    ramp_t rs;
    t = $signed({3'b0, hue, 2'b0} + {4'b0, hue, 1'b0}) + off;
    if (t > SIX_ONE) begin
      t = t - SIX_ONE;
    end else if (t < 21'sd0) begin
      t = t + SIX_ONE;
    end
    back = FOUR_ONE - t;
    if (t < ONE_S) begin
      rs.seg = SEG_RAMP;
      rs.fac = t[15:0];
    end else if (t < THREE_ONE) begin
      rs.seg = SEG_HIGH;
      rs.fac = '0;
    end else if (t < FOUR_ONE) begin
      rs.seg = SEG_RAMP;
      rs.fac = back[15:0];
    end else begin
      rs.seg = SEG_LOW;
      rs.fac = '0;
    end
    return rs;
  endfunction

endpackage

[design/pixel_colorize_hsl.sv]
// Colorize pipeline: luminance -> lightness shift -> HSL to RGB.
// Depends on pch_pkg and assert_macros.svh.
//
// Usage
//   in_*  : stream slave, one RGBA pixel per transaction, tlast marks end of run.
//   out_* : stream master, one colorized RGBA pixel per input, same order,
//           alpha and tlast copied.
//   cfg_* : write-only register port; write only while no pixel is in flight.
//           Index 0 hue, 1 saturation, 2 lightness shift (signed),
//           3..5 red/green/blue luminance weights (65536 = 1.0).
// Throughput: one pixel per cycle while out_tready does not stall the 8-stage pipe;
// s0, s2, s4, s6 hold multipliers, s3, s5, s7 constant divides-by-65535 and clamps.
// Stalls: each stage has its own valid bit and loads when it is empty or the
// stage after it moves, so bubbles collapse and in_tready stays high while any
// stage has room, even with a result waiting at out_*.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to hue 0.5,
// saturation 0.5, shift 0, Rec.709 weights.
`include "assert_macros.svh"

module pixel_colorize_hsl import pch_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input pixels
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                  in_tlast,   // last_in
  // output pixels
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                  out_tlast   // last_out
);

  // ---------------------------------------------------------------- config
  logic [CHAN_W-1:0]  hue_r, sat_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [WGT_W-1:0]   wred_r, wgreen_r, wblue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r    <= 16'd32768;
      sat_r    <= 16'd32768;
      shift_r  <= '0;
      wred_r   <= 17'd13933;
      wgreen_r <= 17'd46871;
      wblue_r  <= 17'd4732;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HUE:    hue_r    <= cfg_wdata[CHAN_W-1:0];
        REG_SAT:    sat_r    <= cfg_wdata[CHAN_W-1:0];
        REG_SHIFT:  shift_r  <= cfg_wdata;
        REG_WRED:   wred_r   <= cfg_wdata;
        REG_WGREEN: wgreen_r <= cfg_wdata;
        REG_WBLUE:  wblue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Lightness shift: magnitude clamped to ONE (catches -65536).
  // lum' = lum*(ONE-|L|)/ONE, plus L when L is positive.
  logic [SHIFT_W-1:0] shift_mag17;
  logic [CHAN_W-1:0]  shift_mag, lfac, shift_pos;
  ramp_t              rs [NCH];

  always_comb begin
    shift_mag17 = shift_r[SHIFT_W-1] ? (17'd0 - shift_r) : shift_r;
    shift_mag   = shift_mag17[16] ? ONE : shift_mag17[15:0];
    lfac        = ONE - shift_mag;
    shift_pos   = shift_r[SHIFT_W-1] ? '0 : shift_r[15:0];
    // red at +120 deg, green at 0, blue at -120 deg
    rs[0] = hue_seg(hue_r, TWO_ONE);
    rs[1] = hue_seg(hue_r, 21'sd0);
    rs[2] = hue_seg(hue_r, -TWO_ONE);
  end

  // ---------------------------------------------------------- flow control
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = en[0];

  // alpha / tlast ride along with every stage
  side_t side_r [NSTG];
  side_t side_nxt [NSTG];

  always_comb begin
    side_nxt[0] = en[0] ? side_t'{alpha: in_tdata[63:48], last: in_tlast} : side_r[0];
    for (int k = 1; k < NSTG; k++) begin
      side_nxt[k] = en[k] ? side_r[k-1] : side_r[k];
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
  end

  // ---------------------------------------------------------------- stages
  logic [32:0] pr_r, pg_r, pb_r, pr_nxt, pg_nxt, pb_nxt;       // s0 weight products
  logic [CHAN_W-1:0] lum0_r, lum0_nxt;                         // s1 luminance
  logic [31:0] lprod_r, lprod_nxt;                             // s2 shift product
  logic [CHAN_W-1:0] lum1_r, lum1_nxt;                         // s3 shifted lum
  logic [32:0] mprod_r, mprod_nxt;                             // s4 m2 product
  logic        hi_r, hi_nxt;
  logic [CHAN_W-1:0] lum2_r, lum2_nxt;
  logic [CHAN_W-1:0] m1_s5_r, m2_s5_r, d_r;                    // s5 m1, m2, m2-m1
  logic [CHAN_W-1:0] m1_s5_nxt, m2_s5_nxt, d_nxt;
  logic [31:0] cprod_r [NCH];                                  // s6 ramp products
  logic [31:0] cprod_nxt [NCH];
  seg_t        seg_r [NCH];
  seg_t        seg_nxt [NCH];
  logic [CHAN_W-1:0] m1_s6_r, m2_s6_r, m1_s6_nxt, m2_s6_nxt;
  logic [CHAN_W-1:0] ch_r [NCH];                               // s7 output channels
  logic [CHAN_W-1:0] ch_nxt [NCH];

  // scratch
  logic [34:0]       wsum;
  logic [CHAN_W-1:0] q3, q5;
  logic [16:0]       add3;
  logic [16:0]       mfac;
  logic signed [18:0] m2_raw, m1_raw;
  logic [CHAN_W-1:0] m1_c, m2_c;
  logic [CHAN_W-1:0] q7 [NCH];
  logic [16:0]       ramp_sum [NCH];

  always_comb begin
    // s0: weights times channels
    pr_nxt = en[0] ? wred_r   * in_tdata[15:0]  : pr_r;
    pg_nxt = en[0] ? wgreen_r * in_tdata[31:16] : pg_r;
    pb_nxt = en[0] ? wblue_r  * in_tdata[47:32] : pb_r;

    // s1: sum, round, saturate
    wsum     = {2'b0, pr_r} + {2'b0, pg_r} + {2'b0, pb_r} + 35'd32768;
    lum0_nxt = en[1] ? ((|wsum[34:32]) ? ONE : wsum[31:16]) : lum0_r;

    // s2
    lprod_nxt = en[2] ? lum0_r * lfac : lprod_r;

    // s3
    q3       = div_one({2'b0, lprod_r} + 34'd32767);
    add3     = {1'b0, q3} + {1'b0, shift_pos};
    lum1_nxt = en[3] ? (add3[16] ? ONE : add3[15:0]) : lum1_r;

    // s4: m2 product, branch on lum above half
    hi_nxt    = en[4] ? (lum1_r > HALF_ONE) : hi_r;
    mfac      = (lum1_r > HALF_ONE) ? {1'b0, sat_r} : ({1'b0, ONE} + {1'b0, sat_r});
    mprod_nxt = en[4] ? lum1_r * mfac : mprod_r;
    lum2_nxt  = en[4] ? lum1_r : lum2_r;

    // s5: m1 / m2, grey when saturation is zero
    q5     = div_one({1'b0, mprod_r} + 34'd32767);
    m2_raw = hi_r ? ($signed({3'b0, lum2_r}) + $signed({3'b0, sat_r})
                     - $signed({3'b0, q5}))
                  : $signed({3'b0, q5});
    if (m2_raw < 19'sd0) begin
      m2_c = '0;
    end else if (m2_raw > $signed({3'b0, ONE})) begin
      m2_c = ONE;
    end else begin
      m2_c = m2_raw[15:0];
    end
    m1_raw = $signed({2'b0, lum2_r, 1'b0}) - $signed({3'b0, m2_c});
    if (m1_raw < 19'sd0) begin
      m1_c = '0;
    end else if (m1_raw > $signed({3'b0, ONE})) begin
      m1_c = ONE;
    end else begin
      m1_c = m1_raw[15:0];
    end
    if (sat_r == '0) begin
      m1_c = lum2_r;
      m2_c = lum2_r;
    end
    m1_s5_nxt = en[5] ? m1_c : m1_s5_r;
    m2_s5_nxt = en[5] ? m2_c : m2_s5_r;
    d_nxt     = en[5] ? (m2_c - m1_c) : d_r;

    // s6: ramp products per channel
    for (int c = 0; c < NCH; c++) begin
      cprod_nxt[c] = en[6] ? d_r * rs[c].fac : cprod_r[c];
      seg_nxt[c]   = en[6] ? rs[c].seg : seg_r[c];
    end
    m1_s6_nxt = en[6] ? m1_s5_r : m1_s6_r;
    m2_s6_nxt = en[6] ? m2_s5_r : m2_s6_r;

    // s7: finish ramp, pick segment
    for (int c = 0; c < NCH; c++) begin
      q7[c]       = div_one({2'b0, cprod_r[c]} + 34'd32767);
      ramp_sum[c] = {1'b0, m1_s6_r} + {1'b0, q7[c]};
      ch_nxt[c]   = ch_r[c];
      if (en[7]) begin
        case (seg_r[c])
          SEG_RAMP: ch_nxt[c] = ramp_sum[c][16] ? ONE : ramp_sum[c][15:0];
          SEG_HIGH: ch_nxt[c] = m2_s6_r;
          SEG_LOW:  ch_nxt[c] = m1_s6_r;
          default:  ch_nxt[c] = m1_s6_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pr_r      <= pr_nxt;
    pg_r      <= pg_nxt;
    pb_r      <= pb_nxt;
    lum0_r    <= lum0_nxt;
    lprod_r   <= lprod_nxt;
    lum1_r    <= lum1_nxt;
    hi_r      <= hi_nxt;
    mprod_r   <= mprod_nxt;
    lum2_r    <= lum2_nxt;
    m1_s5_r   <= m1_s5_nxt;
    m2_s5_r   <= m2_s5_nxt;
    d_r       <= d_nxt;
    cprod_r   <= cprod_nxt;
    seg_r     <= seg_nxt;
    m1_s6_r   <= m1_s6_nxt;
    m2_s6_r   <= m2_s6_nxt;
    ch_r      <= ch_nxt;
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {side_r[NSTG-1].alpha, ch_r[2], ch_r[1], ch_r[0]};
  assign out_tlast  = side_r[NSTG-1].last;

  // ------------------------------------------------------------ assertions
  // an empty output register means every stage can move
  `AST_IMPLY(a_ready_when_drained, !out_tvalid, in_tready)
  // ramp span never negative
  `AST_IMPLY(a_m1_le_m2, vld_r[5], m1_s5_r <= m2_s5_r)
  // zero saturation collapses the ramp to grey
  `AST_IMPLY(a_grey_flat, vld_r[5] && (sat_r == '0), d_r == '0)

endmodule
